@@ rtl/lfa_pkg.sv @@
`default_nettype none

package lfa_pkg;

   // Field widths
   localparam int DIST_W  = 10;
   localparam int TIME_W  = 48;
   localparam int DUTY_W  = 8;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int MS_W    = 16;
   localparam int US_W    = 26;

   // Fixed drive duties and ramp increment
   localparam logic [DUTY_W-1:0] CORRECTION_SPEED = 8'd110;
   localparam logic [DUTY_W-1:0] RESUME_SPEED     = 8'd80;
   localparam logic [DUTY_W-1:0] RAMP_STEP        = 8'd5;
   localparam logic [DUTY_W-1:0] AVOID_SPEED      = 8'd90;

   localparam int US_PER_MS = 1000;

   // Register reset values
   localparam logic [DUTY_W-1:0] DRIVE_SPEED_RST    = 8'd200;
   localparam logic [DIST_W-1:0] WARN_DIST_RST      = 10'd20;
   localparam logic [DIST_W-1:0] STOP_DIST_RST      = 10'd10;
   localparam logic [US_W-1:0]   POST_AVOID_US_RST  = US_W'(300 * US_PER_MS);
   localparam logic [US_W-1:0]   AVOID_CLEAR_US_RST = US_W'(500 * US_PER_MS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RUN_MODE    = 3'd0,
      CSR_MANUAL_MOVE = 3'd1,
      CSR_DRIVE_SPEED = 3'd2,
      CSR_LINE_LEVEL  = 3'd3,
      CSR_WARN_DIST   = 3'd4,
      CSR_STOP_DIST   = 3'd5,
      CSR_POST_AVOID  = 3'd6,
      CSR_AVOID_CLEAR = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      MOVE_STOP    = 3'd0,
      MOVE_FORWARD = 3'd1,
      MOVE_BACK    = 3'd2,
      MOVE_SPIN_L  = 3'd3,
      MOVE_SPIN_R  = 3'd4
   } move_type;

   typedef enum logic [1:0] {
      PHASE_MANUAL = 2'd0,
      PHASE_FOLLOW = 2'd1,
      PHASE_AVOID  = 2'd2,
      PHASE_LIFTED = 2'd3
   } phase_type;

   typedef struct packed {
      logic              run_mode;
      logic [2:0]        manual_move;
      logic [DUTY_W-1:0] drive_speed;
      logic              line_level;
      logic [DIST_W-1:0] warn_dist;
      logic [DIST_W-1:0] stop_dist;
      logic [US_W-1:0]   post_avoid_us;
      logic [US_W-1:0]   avoid_clear_us;
   } cfg_type;

   // Machine restart on a run_mode write
   typedef struct packed {
      logic valid;
      logic auto_mode;
   } restart_type;

   typedef struct packed {
      logic              ir_left;
      logic              ir_center;
      logic              ir_right;
      logic [DIST_W-1:0] dist_left;
      logic [DIST_W-1:0] dist_center;
      logic [DIST_W-1:0] dist_right;
      logic [TIME_W-1:0] now_us;
   } req_word_type;

   typedef struct packed {
      logic [DUTY_W-1:0] motor_a_duty;
      logic              motor_a_forward;
      logic [DUTY_W-1:0] motor_b_duty;
      logic              motor_b_forward;
      logic [1:0]        robot_state;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/lfa_if.sv @@
`default_nettype none

// Update word channel
interface lfa_req_if import lfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              ir_left;
   logic              ir_center;
   logic              ir_right;
   logic [DIST_W-1:0] dist_left;
   logic [DIST_W-1:0] dist_center;
   logic [DIST_W-1:0] dist_right;
   logic [TIME_W-1:0] now_us;

   modport source (output valid, ir_left, ir_center, ir_right,
                   dist_left, dist_center, dist_right, now_us,
                   input ready);
   modport sink (input valid, ir_left, ir_center, ir_right,
                 dist_left, dist_center, dist_right, now_us,
                 output ready);
endinterface

// Motor command channel
interface lfa_rsp_if import lfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] motor_a_duty;
   logic              motor_a_forward;
   logic [DUTY_W-1:0] motor_b_duty;
   logic              motor_b_forward;
   logic [1:0]        robot_state;

   modport source (output valid, motor_a_duty, motor_a_forward,
                   motor_b_duty, motor_b_forward, robot_state,
                   input ready);
   modport sink (input valid, motor_a_duty, motor_a_forward,
                 motor_b_duty, motor_b_forward, robot_state,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/lfa_csr.sv @@
`default_nettype none

module lfa_csr import lfa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output cfg_type                   cfg,
   output restart_type               restart
);

   cfg_type       cfg_ff;
   csr_index_type idx;

   assign idx = csr_index_type'(csr_index);

   // run_mode write restarts the machine in the same edge
   assign restart.valid     = csr_we && (idx == CSR_RUN_MODE);
   assign restart.auto_mode = csr_wdata[0];

   // Register file; millisecond times are kept as microseconds
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_mode       <= 1'b0;
         cfg_ff.manual_move    <= 3'd0;
         cfg_ff.drive_speed    <= DRIVE_SPEED_RST;
         cfg_ff.line_level     <= 1'b1;
         cfg_ff.warn_dist      <= WARN_DIST_RST;
         cfg_ff.stop_dist      <= STOP_DIST_RST;
         cfg_ff.post_avoid_us  <= POST_AVOID_US_RST;
         cfg_ff.avoid_clear_us <= AVOID_CLEAR_US_RST;
      end else if (csr_we) begin
         unique case (idx)
            CSR_RUN_MODE:    cfg_ff.run_mode    <= csr_wdata[0];
            CSR_MANUAL_MOVE: cfg_ff.manual_move <= csr_wdata[2:0];
            CSR_DRIVE_SPEED: cfg_ff.drive_speed <= csr_wdata[DUTY_W-1:0];
            CSR_LINE_LEVEL:  cfg_ff.line_level  <= csr_wdata[0];
            CSR_WARN_DIST:   cfg_ff.warn_dist   <= csr_wdata[DIST_W-1:0];
            CSR_STOP_DIST:   cfg_ff.stop_dist   <= csr_wdata[DIST_W-1:0];
            CSR_POST_AVOID:
               cfg_ff.post_avoid_us <= US_W'(csr_wdata[MS_W-1:0]) * US_W'(US_PER_MS);
            CSR_AVOID_CLEAR:
               cfg_ff.avoid_clear_us <= US_W'(csr_wdata[MS_W-1:0]) * US_W'(US_PER_MS);
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/lfa_engine.sv @@
`default_nettype none

module lfa_engine import lfa_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      go,
   input  wire req_word_type word,
   input  wire cfg_type   cfg,
   input  wire restart_type restart,
   output logic           emit,
   output rsp_word_type   result
);

   typedef enum logic [1:0] {
      SIDE_NONE  = 2'd0,
      SIDE_LEFT  = 2'd1,
      SIDE_RIGHT = 2'd2
   } side_type;

   phase_type         phase_ff, phase_in;
   side_type          side_ff, side_in, side_cur;
   logic [DUTY_W-1:0] ramp_ff, ramp_in;
   logic              clear_valid_ff, clear_valid_in;
   logic              creep_valid_ff, creep_valid_in;
   logic [TIME_W-1:0] clear_since_ff, clear_since_in;
   logic [TIME_W-1:0] creep_since_ff, creep_since_in;

   logic              seen_l, seen_c, seen_r;
   logic              warn_hit, front, l_close, r_close;
   logic [TIME_W-1:0] creep_el, clear_el, since_cur;
   logic              creep_active, clear_keep, clear_done;
   logic [DUTY_W-1:0] ramp_base, ramp_up, ramp_follow;
   logic [DUTY_W:0]   ramp_sum;
   logic [DUTY_W-1:0] duty_a, duty_b;
   logic              fwd_a, fwd_b;

   // Sensor decode
   assign seen_l = (word.ir_left == cfg.line_level);
   assign seen_c = (word.ir_center == cfg.line_level);
   assign seen_r = (word.ir_right == cfg.line_level);

   assign warn_hit = (word.dist_left < cfg.warn_dist) || (word.dist_center < cfg.warn_dist)
                  || (word.dist_right < cfg.warn_dist);
   assign front    = word.dist_center < cfg.warn_dist;
   assign l_close  = word.dist_left < cfg.stop_dist;
   assign r_close  = word.dist_right < cfg.stop_dist;

   // Creep timer after avoidance
   assign creep_el     = word.now_us - creep_since_ff;
   assign creep_active = creep_valid_ff && (creep_el < TIME_W'(cfg.post_avoid_us));

   // Avoid side is picked on the first avoiding step
   always_comb begin
      if (side_ff == SIDE_LEFT || side_ff == SIDE_RIGHT) begin
         side_cur = side_ff;
      end else if (word.dist_left >= word.dist_right) begin
         side_cur = SIDE_LEFT;
      end else begin
         side_cur = SIDE_RIGHT;
      end
   end

   // Clear interval timer
   assign clear_keep = (side_ff == SIDE_LEFT || side_ff == SIDE_RIGHT) && clear_valid_ff;
   assign since_cur  = clear_keep ? clear_since_ff : word.now_us;
   assign clear_el   = word.now_us - since_cur;
   assign clear_done = clear_el > TIME_W'(cfg.avoid_clear_us);

   // Forward ramp, capped at drive_speed; a base already above drive_speed is kept
   assign ramp_base   = creep_valid_ff ? RESUME_SPEED : ramp_ff;
   assign ramp_sum    = {1'b0, ramp_base} + {1'b0, RAMP_STEP};
   assign ramp_up     = (ramp_sum > {1'b0, cfg.drive_speed}) ? cfg.drive_speed
                                                             : ramp_sum[DUTY_W-1:0];
   assign ramp_follow = (ramp_base < cfg.drive_speed) ? ramp_up : ramp_base;

   // Decision and next state
   always_comb begin
      phase_in       = phase_ff;
      side_in        = side_ff;
      ramp_in        = ramp_ff;
      clear_valid_in = clear_valid_ff;
      clear_since_in = clear_since_ff;
      creep_valid_in = creep_valid_ff;
      creep_since_in = creep_since_ff;
      emit   = 1'b0;
      duty_a = '0;
      fwd_a  = 1'b1;
      duty_b = '0;
      fwd_b  = 1'b1;

      if (!cfg.run_mode) begin
         emit = 1'b1;
         unique case (cfg.manual_move)
            MOVE_FORWARD: begin
               duty_a = cfg.drive_speed; duty_b = cfg.drive_speed;
            end
            MOVE_BACK: begin
               duty_a = cfg.drive_speed; duty_b = cfg.drive_speed;
               fwd_a = 1'b0; fwd_b = 1'b0;
            end
            MOVE_SPIN_L: begin
               duty_a = cfg.drive_speed; duty_b = cfg.drive_speed;
               fwd_a = 1'b0;
            end
            MOVE_SPIN_R: begin
               duty_a = cfg.drive_speed; duty_b = cfg.drive_speed;
               fwd_b = 1'b0;
            end
            default: ;
         endcase
      end else begin
         unique case (phase_ff)
            PHASE_FOLLOW: begin
               if (warn_hit) begin
                  phase_in       = PHASE_AVOID;
                  clear_valid_in = 1'b0;
                  creep_valid_in = 1'b0;
                  side_in        = SIDE_NONE;
               end else if (creep_active) begin
                  emit = 1'b1;
                  duty_a = cfg.drive_speed; duty_b = cfg.drive_speed;
               end else begin
                  emit           = 1'b1;
                  creep_valid_in = 1'b0;
                  ramp_in        = RESUME_SPEED;
                  if (!seen_l && !seen_c && !seen_r) begin
                     phase_in = PHASE_LIFTED;
                  end else if (!seen_c) begin
                     if (seen_l && !seen_r) begin
                        duty_a = CORRECTION_SPEED; duty_b = CORRECTION_SPEED;
                        fwd_b = 1'b0;
                     end else if (!seen_l && seen_r) begin
                        duty_a = CORRECTION_SPEED; duty_b = CORRECTION_SPEED;
                        fwd_a = 1'b0;
                     end else begin
                        duty_a = RESUME_SPEED; duty_b = RESUME_SPEED;
                     end
                  end else if (seen_l && !seen_r) begin
                     duty_a = CORRECTION_SPEED;
                  end else if (!seen_l && seen_r) begin
                     duty_b = CORRECTION_SPEED;
                  end else begin
                     ramp_in = ramp_follow;
                     duty_a  = ramp_follow; duty_b = ramp_follow;
                  end
               end
            end
            PHASE_AVOID: begin
               side_in        = side_cur;
               clear_valid_in = 1'b0;
               if (front) begin
                  emit = 1'b1;
                  if (side_cur == SIDE_RIGHT) begin
                     duty_a = AVOID_SPEED;
                  end else begin
                     duty_b = AVOID_SPEED;
                  end
               end else if ((side_cur == SIDE_RIGHT && r_close)
                            || (side_cur == SIDE_LEFT && l_close)) begin
                  emit    = 1'b1;
                  side_in = (side_cur == SIDE_RIGHT) ? SIDE_LEFT : SIDE_RIGHT;
               end else if (l_close || r_close) begin
                  emit = 1'b1;
               end else if (clear_done) begin
                  side_in        = SIDE_NONE;
                  creep_since_in = word.now_us;
                  creep_valid_in = 1'b1;
                  ramp_in        = RESUME_SPEED;
                  phase_in       = PHASE_FOLLOW;
               end else begin
                  emit           = 1'b1;
                  clear_valid_in = 1'b1;
                  clear_since_in = since_cur;
                  duty_a = AVOID_SPEED; duty_b = AVOID_SPEED;
               end
            end
            PHASE_LIFTED: begin
               if (seen_l || seen_c || seen_r) begin
                  ramp_in  = RESUME_SPEED;
                  phase_in = PHASE_FOLLOW;
               end else begin
                  emit = 1'b1;
               end
            end
            PHASE_MANUAL: ;
            default: ;
         endcase
      end
   end

   assign result.motor_a_duty    = duty_a;
   assign result.motor_a_forward = fwd_a;
   assign result.motor_b_duty    = duty_b;
   assign result.motor_b_forward = fwd_b;
   assign result.robot_state     = phase_in;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_MANUAL;
         side_ff        <= SIDE_NONE;
         ramp_ff        <= RESUME_SPEED;
         clear_valid_ff <= 1'b0;
         creep_valid_ff <= 1'b0;
      end else if (restart.valid) begin
         phase_ff       <= restart.auto_mode ? PHASE_LIFTED : PHASE_MANUAL;
         side_ff        <= SIDE_NONE;
         ramp_ff        <= RESUME_SPEED;
         clear_valid_ff <= 1'b0;
         creep_valid_ff <= 1'b0;
      end else if (go) begin
         phase_ff       <= phase_in;
         side_ff        <= side_in;
         ramp_ff        <= ramp_in;
         clear_valid_ff <= clear_valid_in;
         creep_valid_ff <= creep_valid_in;
      end
   end

   // Timestamps, only read while their valid bit is set
   always_ff @(posedge clock) begin
      if (go) begin
         clear_since_ff <= clear_since_in;
         creep_since_ff <= creep_since_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/line_follow_avoid_controller_core.sv @@
`default_nettype none

// Line follow / obstacle avoid controller. Each update word on req_ch
// (three line sensors, three distances in cm, a microsecond timestamp)
// yields at most one motor command word on rsp_ch; the steps that enter
// or end avoidance, and the step that leaves the lifted state, yield no
// word. Words are taken one per clock unless rsp_ch stalls: the update
// passes an input register, the decision logic and a result register,
// and its command is presented on rsp_ch from the result register.
// Configuration goes through the csr_ port; the user must write it only
// while no update is in flight, as the block does not enforce this;
// writing run_mode restarts the robot state (lifted in autonomous mode,
// manual otherwise).
module line_follow_avoid_controller_core import lfa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   lfa_req_if.sink                   req_ch,
   lfa_rsp_if.source                 rsp_ch
);

   cfg_type      cfg;
   restart_type  restart;
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   logic         advance;
   logic         emit;
   rsp_word_type result;

   lfa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .restart   (restart)
   );

   // Update moves to the result stage when that stage is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_word_ff.ir_left     <= req_ch.ir_left;
         in_word_ff.ir_center   <= req_ch.ir_center;
         in_word_ff.ir_right    <= req_ch.ir_right;
         in_word_ff.dist_left   <= req_ch.dist_left;
         in_word_ff.dist_center <= req_ch.dist_center;
         in_word_ff.dist_right  <= req_ch.dist_right;
         in_word_ff.now_us      <= req_ch.now_us;
      end
   end

   lfa_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .go      (advance),
      .word    (in_word_ff),
      .cfg     (cfg),
      .restart (restart),
      .emit    (emit),
      .result  (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_word_ff <= result;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.motor_a_duty    = out_word_ff.motor_a_duty;
   assign rsp_ch.motor_a_forward = out_word_ff.motor_a_forward;
   assign rsp_ch.motor_b_duty    = out_word_ff.motor_b_duty;
   assign rsp_ch.motor_b_forward = out_word_ff.motor_b_forward;
   assign rsp_ch.robot_state     = out_word_ff.robot_state;

endmodule

`default_nettype wire

@@ test/tb_line_follow_avoid_controller_core.sv @@
`timescale 1ns / 1ps

module tb_line_follow_avoid_controller_core;
   import lfa_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_PER_PROFILE = 125;
   localparam int MAX_PRINTED = 50;

   typedef enum logic [1:0] {
      SIDE_NONE  = 2'd0,
      SIDE_LEFT  = 2'd1,
      SIDE_RIGHT = 2'd2
   } avoid_side_type;

   // Tracks the robot controller state and the motor commands it must emit
   class motor_cmd_board;
      logic              auto_mode;
      logic [2:0]        move;
      logic [DUTY_W-1:0] speed;
      logic              level;
      logic [DIST_W-1:0] warn;
      logic [DIST_W-1:0] stop;
      logic [MS_W-1:0]   post_ms;
      logic [MS_W-1:0]   clear_ms;

      phase_type         phase;
      avoid_side_type    side;
      logic [DUTY_W-1:0] ramp;
      logic [TIME_W-1:0] clear_t;
      logic [TIME_W-1:0] creep_t;
      logic              clear_ok;
      logic              creep_ok;

      rsp_word_type      expected_cmds[$];
      int                fail_count;

      function new();
         auto_mode = 1'b0;
         move = MOVE_STOP;
         speed = DRIVE_SPEED_RST;
         level = 1'b1;
         warn = WARN_DIST_RST;
         stop = STOP_DIST_RST;
         post_ms = 16'd300;
         clear_ms = 16'd500;
         fail_count = 0;
         restart();
      endfunction

      function void restart();
         phase = auto_mode ? PHASE_LIFTED : PHASE_MANUAL;
         side = SIDE_NONE;
         ramp = RESUME_SPEED;
         clear_t = '0;
         clear_ok = 1'b0;
         creep_t = '0;
         creep_ok = 1'b0;
      endfunction

      function void report(string msg);
         if (fail_count < MAX_PRINTED)
            $display("ERROR %0t: %s", $time, msg);
         fail_count++;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_W-1:0] v);
         case (idx)
            CSR_RUN_MODE: begin
               auto_mode = v[0];
               restart();
            end
            CSR_MANUAL_MOVE: move = v[2:0];
            CSR_DRIVE_SPEED: speed = v[DUTY_W-1:0];
            CSR_LINE_LEVEL:  level = v[0];
            CSR_WARN_DIST:   warn = v[DIST_W-1:0];
            CSR_STOP_DIST:   stop = v[DIST_W-1:0];
            CSR_POST_AVOID:  post_ms = v;
            CSR_AVOID_CLEAR: clear_ms = v;
            default: ;
         endcase
      endfunction

      function void push_cmd(logic [DUTY_W-1:0] a, logic fa, logic [DUTY_W-1:0] b, logic fb);
         rsp_word_type cmd;
         cmd.motor_a_duty = a;
         cmd.motor_a_forward = fa;
         cmd.motor_b_duty = b;
         cmd.motor_b_forward = fb;
         cmd.robot_state = phase;
         expected_cmds.push_back(cmd);
      endfunction

      function void halt_cmd();
         push_cmd('0, 1'b1, '0, 1'b1);
      endfunction

      // One control update; queues the command it produces, if any
      function void note_update(req_word_type w);
         logic              l, c, r;
         logic              front, lclose, rclose;
         logic [DIST_W-1:0] nearest;
         logic [DUTY_W:0]   next_ramp;
         logic [TIME_W-1:0] elapsed;
         longint unsigned   span_us;

         l = (w.ir_left == level);
         c = (w.ir_center == level);
         r = (w.ir_right == level);

         if (!auto_mode) begin
            case (move)
               MOVE_FORWARD: push_cmd(speed, 1'b1, speed, 1'b1);
               MOVE_BACK:    push_cmd(speed, 1'b0, speed, 1'b0);
               MOVE_SPIN_L:  push_cmd(speed, 1'b0, speed, 1'b1);
               MOVE_SPIN_R:  push_cmd(speed, 1'b1, speed, 1'b0);
               default:      halt_cmd();
            endcase
            return;
         end

         case (phase)
            PHASE_LIFTED: begin
               if (l || c || r) begin
                  ramp = RESUME_SPEED;
                  phase = PHASE_FOLLOW;
               end else begin
                  halt_cmd();
               end
            end

            PHASE_AVOID: begin
               if (side == SIDE_NONE) begin
                  side = (w.dist_left >= w.dist_right) ? SIDE_LEFT : SIDE_RIGHT;
                  clear_ok = 1'b0;
               end
               front = w.dist_center < warn;
               lclose = w.dist_left < stop;
               rclose = w.dist_right < stop;
               if (front) begin
                  clear_ok = 1'b0;
                  if (side == SIDE_RIGHT)
                     push_cmd(AVOID_SPEED, 1'b1, '0, 1'b1);
                  else
                     push_cmd('0, 1'b1, AVOID_SPEED, 1'b1);
               end else if ((side == SIDE_RIGHT && rclose) || (side == SIDE_LEFT && lclose)) begin
                  // chosen side got too close: flip and pause
                  side = (side == SIDE_RIGHT) ? SIDE_LEFT : SIDE_RIGHT;
                  clear_ok = 1'b0;
                  halt_cmd();
               end else if (lclose || rclose) begin
                  clear_ok = 1'b0;
                  halt_cmd();
               end else begin
                  if (!clear_ok) begin
                     clear_t = w.now_us;
                     clear_ok = 1'b1;
                  end
                  elapsed = w.now_us - clear_t;
                  span_us = longint'(clear_ms) * US_PER_MS;
                  if (longint'(elapsed) > span_us) begin
                     // clear long enough: back to following with a creep
                     clear_ok = 1'b0;
                     side = SIDE_NONE;
                     creep_t = w.now_us;
                     creep_ok = 1'b1;
                     ramp = RESUME_SPEED;
                     phase = PHASE_FOLLOW;
                  end else begin
                     push_cmd(AVOID_SPEED, 1'b1, AVOID_SPEED, 1'b1);
                  end
               end
            end

            PHASE_FOLLOW: begin
               nearest = w.dist_left;
               if (w.dist_center < nearest) nearest = w.dist_center;
               if (w.dist_right < nearest) nearest = w.dist_right;
               if (nearest < warn) begin
                  phase = PHASE_AVOID;
                  clear_ok = 1'b0;
                  creep_ok = 1'b0;
                  side = SIDE_NONE;
                  return;
               end
               if (creep_ok) begin
                  elapsed = w.now_us - creep_t;
                  span_us = longint'(post_ms) * US_PER_MS;
                  if (longint'(elapsed) < span_us) begin
                     push_cmd(speed, 1'b1, speed, 1'b1);
                     return;
                  end
                  ramp = RESUME_SPEED;
                  creep_ok = 1'b0;
               end
               if (!l && !c && !r) begin
                  ramp = RESUME_SPEED;
                  phase = PHASE_LIFTED;
                  halt_cmd();
               end else if (!c) begin
                  ramp = RESUME_SPEED;
                  if (l && !r)
                     push_cmd(CORRECTION_SPEED, 1'b1, CORRECTION_SPEED, 1'b0);
                  else if (!l && r)
                     push_cmd(CORRECTION_SPEED, 1'b0, CORRECTION_SPEED, 1'b1);
                  else
                     push_cmd(RESUME_SPEED, 1'b1, RESUME_SPEED, 1'b1);
               end else if (l && !r) begin
                  ramp = RESUME_SPEED;
                  push_cmd(CORRECTION_SPEED, 1'b1, '0, 1'b1);
               end else if (!l && r) begin
                  ramp = RESUME_SPEED;
                  push_cmd('0, 1'b1, CORRECTION_SPEED, 1'b1);
               end else begin
                  // on the line: ramp up toward drive speed
                  if (ramp < speed) begin
                     next_ramp = ramp + RAMP_STEP;
                     ramp = (next_ramp > speed) ? speed : next_ramp[DUTY_W-1:0];
                  end
                  push_cmd(ramp, 1'b1, ramp, 1'b1);
               end
            end

            default: ; // manual phase in autonomous mode emits nothing
         endcase
      endfunction

      function void check_cmd(rsp_word_type got);
         rsp_word_type want;
         if (expected_cmds.size() == 0) begin
            report($sformatf("unexpected command %h", got));
            return;
         end
         want = expected_cmds.pop_front();
         if (got.motor_a_duty != want.motor_a_duty)
            report($sformatf("motor_a_duty %0d, expected %0d",
                             got.motor_a_duty, want.motor_a_duty));
         if (got.motor_a_forward != want.motor_a_forward)
            report($sformatf("motor_a_forward %0b, expected %0b",
                             got.motor_a_forward, want.motor_a_forward));
         if (got.motor_b_duty != want.motor_b_duty)
            report($sformatf("motor_b_duty %0d, expected %0d",
                             got.motor_b_duty, want.motor_b_duty));
         if (got.motor_b_forward != want.motor_b_forward)
            report($sformatf("motor_b_forward %0b, expected %0b",
                             got.motor_b_forward, want.motor_b_forward));
         if (got.robot_state != want.robot_state)
            report($sformatf("robot_state %0d, expected %0d",
                             got.robot_state, want.robot_state));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   lfa_req_if req_ch ();
   lfa_rsp_if rsp_ch ();

   line_follow_avoid_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   motor_cmd_board board;
   req_word_type   seen_update;
   rsp_word_type   seen_cmd;
   int             req_idle_pct = 27;
   int             rsp_idle_pct = 66;
   int             quiet_cycles = 0;
   logic [TIME_W-1:0] t_now;

   always #1 clock = ~clock;

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Observe both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && board != null) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_update.ir_left = req_ch.ir_left;
            seen_update.ir_center = req_ch.ir_center;
            seen_update.ir_right = req_ch.ir_right;
            seen_update.dist_left = req_ch.dist_left;
            seen_update.dist_center = req_ch.dist_center;
            seen_update.dist_right = req_ch.dist_right;
            seen_update.now_us = req_ch.now_us;
            board.note_update(seen_update);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_cmd.motor_a_duty = rsp_ch.motor_a_duty;
            seen_cmd.motor_a_forward = rsp_ch.motor_a_forward;
            seen_cmd.motor_b_duty = rsp_ch.motor_b_duty;
            seen_cmd.motor_b_forward = rsp_ch.motor_b_forward;
            seen_cmd.robot_state = rsp_ch.robot_state;
            board.check_cmd(seen_cmd);
         end
      end
   end

   // Watchdog: too long without any handshake or register write
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Register write; we is dropped again before the task returns, so back-to-back writes each toggle we
   task automatic csr_write(csr_index_type idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Present one word and hold it until taken; returns at a falling edge
   task automatic send_update(req_word_type w);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.ir_left <= w.ir_left;
      req_ch.ir_center <= w.ir_center;
      req_ch.ir_right <= w.ir_right;
      req_ch.dist_left <= w.dist_left;
      req_ch.dist_center <= w.dist_center;
      req_ch.dist_right <= w.dist_right;
      req_ch.now_us <= w.now_us;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic put(logic l, logic c, logic r, logic [DIST_W-1:0] dl,
                      logic [DIST_W-1:0] dc, logic [DIST_W-1:0] dr, logic [TIME_W-1:0] t);
      req_word_type w;
      w.ir_left = l;
      w.ir_center = c;
      w.ir_right = r;
      w.dist_left = dl;
      w.dist_center = dc;
      w.dist_right = dr;
      w.now_us = t;
      send_update(w);
   endtask

   // Stop sending and wait until every command is in, plus pipeline slack
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.expected_cmds.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [DIST_W-1:0] near_dist(int unsigned lim);
      return (lim == 0) ? '0 : DIST_W'($urandom_range(lim - 1, 0));
   endfunction

   function automatic logic [DIST_W-1:0] far_dist();
      int unsigned lo;
      lo = (board.warn > board.stop) ? board.warn : board.stop;
      return DIST_W'($urandom_range(1023, lo));
   endfunction

   // Random update: mostly plausible scenes on an advancing clock
   function automatic req_word_type make_update();
      req_word_type w;
      int           scene;
      int           pick;
      int unsigned  span;
      w.ir_left = 1'($urandom_range(1));
      w.ir_center = 1'($urandom_range(1));
      w.ir_right = 1'($urandom_range(1));
      w.dist_left = far_dist();
      w.dist_center = far_dist();
      w.dist_right = far_dist();
      scene = $urandom_range(99);
      if (scene >= 60 && scene < 75) begin
         w.dist_center = near_dist(board.warn);
      end else if (scene >= 75 && scene < 90) begin
         if ($urandom_range(1))
            w.dist_left = near_dist(board.stop);
         else
            w.dist_right = near_dist(board.stop);
      end else if (scene >= 90) begin
         w.dist_left = DIST_W'($urandom_range(1023, 0));
         w.dist_center = DIST_W'($urandom_range(1023, 0));
         w.dist_right = DIST_W'($urandom_range(1023, 0));
      end
      pick = $urandom_range(99);
      span = ((board.clear_ms > board.post_ms) ? board.clear_ms : board.post_ms);
      if (pick < 65)
         t_now = t_now + $urandom_range(3000, 0);
      else if (pick < 90)
         t_now = t_now + $urandom_range(span * 2000 + 2000, 0);
      else if (pick < 95)
         t_now = t_now + TIME_W'({$urandom, $urandom});
      else
         t_now = TIME_W'({$urandom, $urandom});
      w.now_us = t_now;
      return w;
   endfunction

   // kind 0: all minimums but run_mode set, kind 1: all maximums, otherwise random
   task automatic load_settings(int kind);
      logic [CSR_W-1:0] v;
      if (kind == 0) begin
         csr_write(CSR_MANUAL_MOVE, CSR_W'(MOVE_STOP));
         csr_write(CSR_DRIVE_SPEED, '0);
         csr_write(CSR_LINE_LEVEL, '0);
         csr_write(CSR_WARN_DIST, '0);
         csr_write(CSR_STOP_DIST, '0);
         csr_write(CSR_POST_AVOID, '0);
         csr_write(CSR_AVOID_CLEAR, '0);
         csr_write(CSR_RUN_MODE, CSR_W'(1));
      end else if (kind == 1) begin
         csr_write(CSR_MANUAL_MOVE, CSR_W'(7));
         csr_write(CSR_DRIVE_SPEED, CSR_W'(255));
         csr_write(CSR_LINE_LEVEL, CSR_W'(1));
         csr_write(CSR_WARN_DIST, CSR_W'(1023));
         csr_write(CSR_STOP_DIST, CSR_W'(1023));
         csr_write(CSR_POST_AVOID, CSR_W'(65535));
         csr_write(CSR_AVOID_CLEAR, CSR_W'(65535));
         csr_write(CSR_RUN_MODE, CSR_W'(1));
      end else begin
         csr_write(CSR_MANUAL_MOVE, CSR_W'($urandom_range(7)));
         case ($urandom_range(3))
            0: v = '0;
            1: v = CSR_W'(255);
            default: v = CSR_W'($urandom_range(255));
         endcase
         csr_write(CSR_DRIVE_SPEED, v);
         csr_write(CSR_LINE_LEVEL, CSR_W'($urandom_range(1)));
         v = ($urandom_range(9) == 0) ? CSR_W'($urandom_range(1023)) : CSR_W'($urandom_range(120));
         csr_write(CSR_WARN_DIST, v);
         csr_write(CSR_STOP_DIST, CSR_W'($urandom_range(60)));
         v = ($urandom_range(9) == 0) ? CSR_W'(65535) : CSR_W'($urandom_range(50));
         csr_write(CSR_POST_AVOID, v);
         v = ($urandom_range(9) == 0) ? CSR_W'(65535) : CSR_W'($urandom_range(50));
         csr_write(CSR_AVOID_CLEAR, v);
         csr_write(CSR_RUN_MODE, CSR_W'($urandom_range(99) < 85));
      end
   endtask

   initial begin
      int sent;
      int batch;
      int round;

      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_RUN_MODE;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.ir_left = 1'b0;
      req_ch.ir_center = 1'b0;
      req_ch.ir_right = 1'b0;
      req_ch.dist_left = '0;
      req_ch.dist_center = '0;
      req_ch.dist_right = '0;
      req_ch.now_us = '0;
      rsp_ch.ready = 1'b0;
      t_now = '0;
      board = new();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Manual moves, unknown codes included, at both speed extremes
      for (int m = 0; m < 8; m++) begin
         drain();
         if (m == 0) csr_write(CSR_DRIVE_SPEED, '0);
         if (m == 4) csr_write(CSR_DRIVE_SPEED, CSR_W'(255));
         csr_write(CSR_MANUAL_MOVE, CSR_W'(m));
         put(1'b1, 1'b0, 1'b1, 10'd1023, 10'd0, 10'd512, 48'd0);
      end

      // Autonomous walk: lifted, following, ramp cap, corrections
      drain();
      csr_write(CSR_DRIVE_SPEED, CSR_W'(90));
      csr_write(CSR_RUN_MODE, CSR_W'(1));
      put(1'b0, 1'b0, 1'b0, 10'd1023, 10'd1023, 10'd1023, 48'd0);
      put(1'b0, 1'b1, 1'b0, 10'd1023, 10'd1023, 10'd1023, 48'd100);
      put(1'b0, 1'b1, 1'b0, 10'd1023, 10'd1023, 10'd1023, 48'd200);
      put(1'b1, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd300);
      put(1'b1, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd400);
      put(1'b1, 1'b1, 1'b0, 10'd1023, 10'd1023, 10'd1023, 48'd500);
      put(1'b0, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd600);
      put(1'b1, 1'b0, 1'b0, 10'd1023, 10'd1023, 10'd1023, 48'd700);
      put(1'b0, 1'b0, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd800);
      put(1'b1, 1'b0, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd900);
      // obstacle ahead, side choice, flips, pause on the other side
      put(1'b0, 1'b1, 1'b0, 10'd1023, 10'd0, 10'd1023, 48'd1000);
      put(1'b0, 1'b1, 1'b0, 10'd1023, 10'd0, 10'd5, 48'd1100);
      put(1'b0, 1'b1, 1'b0, 10'd5, 10'd500, 10'd1023, 48'd1200);
      put(1'b0, 1'b1, 1'b0, 10'd500, 10'd500, 10'd5, 48'd1300);
      put(1'b0, 1'b1, 1'b0, 10'd500, 10'd500, 10'd5, 48'd1400);
      // clear interval across the timestamp wrap, then creep, then line
      put(1'b1, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'hFFFF_FFFF_FC18);
      put(1'b1, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd499001);
      put(1'b1, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd500001);
      put(1'b1, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd900000);
      put(1'b0, 1'b0, 1'b0, 10'd1023, 10'd1023, 10'd1023, 48'd900100);

      // Inverted line level, drive speed below the resume speed
      drain();
      csr_write(CSR_LINE_LEVEL, '0);
      csr_write(CSR_DRIVE_SPEED, CSR_W'(50));
      csr_write(CSR_RUN_MODE, CSR_W'(1));
      put(1'b1, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd10);
      put(1'b0, 1'b0, 1'b0, 10'd1023, 10'd1023, 10'd1023, 48'd20);
      put(1'b1, 1'b0, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd30);
      put(1'b1, 1'b0, 1'b1, 10'd1023, 10'd1023, 10'd1023, 48'd40);

      // Random traffic under three backpressure profiles
      for (int prof = 0; prof < 3; prof++) begin
         drain();
         req_idle_pct = (prof == 0) ? 27 : (prof == 1) ? 66 : 0;
         rsp_idle_pct = (prof == 0) ? 66 : (prof == 1) ? 27 : 0;
         sent = 0;
         round = 0;
         while (sent < RANDOM_PER_PROFILE) begin
            drain();
            load_settings((round == 0 && prof < 2) ? prof : 2);
            if ($urandom_range(3) == 0)
               t_now = 48'hFFFF_FFFF_FFFF - $urandom_range(100000, 0);
            batch = $urandom_range(40, 20);
            for (int i = 0; i < batch; i++)
               send_update(make_update());
            sent += batch;
            round++;
         end
      end

      drain();
      while (board.expected_cmds.size() != 0) begin
         board.report("expected command never arrived");
         void'(board.expected_cmds.pop_front());
      end
      if (board.fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
